// ----- src/rbwd_pkg.sv -----
package rbwd_pkg;

    localparam int RELAY_W   = 6;
    localparam int COUNT_W   = 16;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W   = 16;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CMD  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic step;
        logic is_cmd;
        logic mask_bit;
        logic desired_bit;
    } lane_ctrl_t;

    typedef struct packed {
        logic on;
        logic forced;
    } lane_stat_t;

endpackage

// ----- src/relay_bank_with_on_time_watchdog.sv -----
// path from input transfer to result: input register, then result register
// throughput: one item per cycle while the result side is not stalled; all relay lanes update in parallel in one pass
// an input transfer is taken while a finished result waits, up to one item deep
// reset (aresetn low, synchronous): all relays off, on-time counters, status
// tick counter and all limits cleared, both channels empty
module relay_bank_with_on_time_watchdog #(
    parameter int RELAY_COUNT   = 6,
    parameter int STATUS_PERIOD = 200
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbwd_pkg::TDATA_W-1:0]      s_tdata,   // mask, desired
    input  logic                              s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbwd_pkg::TDATA_W-1:0]      m_tdata,   // relay_bits, forced_off
    output logic                              m_tuser,   // status_due
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbwd_pkg::COUNT_W-1:0]      cfg_wdata
);
    import rbwd_pkg::*;

    localparam int TICK_W = $clog2(STATUS_PERIOD + 1);
    localparam int PAD_W  = TDATA_W - 2 * RELAY_W;

    logic                in_valid_reg;
    logic                in_func_reg;
    logic [RELAY_W-1:0]  in_mask_reg;
    logic [RELAY_W-1:0]  in_desired_reg;

    logic                m_tvalid_reg;
    logic [RELAY_W-1:0]  state_reg;
    logic [RELAY_W-1:0]  forced_reg;
    logic                due_reg;

    logic [TICK_W-1:0]   tick_count_reg;
    logic [TICK_W-1:0]   tick_count_next;
    logic [TICK_W:0]     tick_sum;
    logic                tick_wrap;

    count_t              limit_reg [RELAY_COUNT];
    lane_stat_t          lane_stat [RELAY_COUNT];

    logic [RELAY_W-1:0]  state_next;
    logic [RELAY_W-1:0]  forced_next;
    logic [RELAY_W-1:0]  relay_mask;
    logic                due_next;
    logic                proceed;
    logic                s_xfer;

    assign proceed  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || proceed;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_func_reg    <= s_tuser;
            in_mask_reg    <= s_tdata[RELAY_W-1:0];
            in_desired_reg <= s_tdata[2*RELAY_W-1:RELAY_W];
        end
    end

    // limit registers
    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < RELAY_COUNT; i++) begin : g_limit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                limit_reg[i] <= '0;
            end else if (cfg_valid && (cfg_index == CFG_IDX_W'(i))) begin
                limit_reg[i] <= cfg_wdata;
            end
        end
    end

    // relay lanes
    for (genvar i = 0; i < RELAY_W; i++) begin : g_lane
        if (i < RELAY_COUNT) begin : g_used
            lane_ctrl_t ctrl;

            assign ctrl.step        = proceed;
            assign ctrl.is_cmd      = (in_func_reg == FUNC_CMD);
            assign ctrl.mask_bit    = in_mask_reg[i];
            assign ctrl.desired_bit = in_desired_reg[i];

            rbwd_relay_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .limit   (limit_reg[i]),
                .stat    (lane_stat[i])
            );

            assign state_next[i]  = lane_stat[i].on;
            assign forced_next[i] = lane_stat[i].forced;
            assign relay_mask[i]  = 1'b1;
        end else begin : g_unused
            assign state_next[i]  = 1'b0;
            assign forced_next[i] = 1'b0;
            assign relay_mask[i]  = 1'b0;
        end
    end

    // status period
    assign tick_sum        = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign tick_wrap       = tick_sum >= (TICK_W+1)'(STATUS_PERIOD);
    assign tick_count_next = tick_wrap ? '0 : tick_sum[TICK_W-1:0];

    always_comb begin
        if (in_func_reg == FUNC_CMD) begin
            due_next = 1'b1;
        end else begin
            due_next = tick_wrap || (forced_next != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else if (proceed && (in_func_reg == FUNC_TICK)) begin
            tick_count_reg <= tick_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (proceed) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            state_reg  <= state_next;
            forced_reg <= forced_next;
            due_reg    <= due_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, forced_reg, state_reg};
    assign m_tuser  = due_reg;

    a_forced_is_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((forced_reg & state_reg) == '0))
        else $error("forced relay reported on");

    a_forced_raises_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (forced_reg != '0)) |-> due_reg)
        else $error("forced off without status due");

    a_unused_relays_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((state_reg & ~relay_mask) == '0))
        else $error("relay beyond bank reported on");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed |=> m_tvalid_reg)
        else $error("processed item left no result");

    a_tick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, tick_count_reg} < (TICK_W+1)'(STATUS_PERIOD))
        else $error("status tick counter out of range");

endmodule

// ----- src/rbwd_relay_lane.sv -----
module rbwd_relay_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbwd_pkg::lane_ctrl_t ctrl,
    input  rbwd_pkg::count_t    limit,
    output rbwd_pkg::lane_stat_t stat
);
    import rbwd_pkg::*;

    logic   on_reg;
    logic   on_next;
    count_t count_reg;
    count_t count_next;
    count_t count_inc;
    logic   forced;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + count_t'(1);

    always_comb begin
        on_next    = on_reg;
        count_next = count_reg;
        forced     = 1'b0;
        if (ctrl.is_cmd) begin
            if (ctrl.mask_bit) begin
                if (ctrl.desired_bit) begin
                    on_next = 1'b1;
                    if (!on_reg) begin
                        count_next = '0;
                    end
                end else begin
                    on_next = 1'b0;
                end
            end
        end else if (on_reg && (limit != '0)) begin
            count_next = count_inc;
            if (count_inc >= limit) begin
                on_next = 1'b0;
                forced  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg    <= 1'b0;
            count_reg <= '0;
        end else if (ctrl.step) begin
            on_reg    <= on_next;
            count_reg <= count_next;
        end
    end

    assign stat.on     = on_next;
    assign stat.forced = forced;

endmodule

// ----- dv/relay_bank_with_on_time_watchdog_test.sv -----
`timescale 1ns / 1ps

module relay_bank_with_on_time_watchdog_test;
    import rbwd_pkg::*;

    localparam int RELAY_COUNT    = 6;
    localparam int STATUS_PERIOD  = 200;
    localparam logic [RELAY_W-1:0] LIVE_MASK = RELAY_W'((1 << RELAY_COUNT) - 1);
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 215;
    localparam int RANDOM_PHASES  = 6;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    typedef struct packed {
        logic               func;
        logic [RELAY_W-1:0] mask;
        logic [RELAY_W-1:0] desired;
    } relay_item_t;

    typedef struct packed {
        logic [RELAY_W-1:0] relay_bits;
        logic [RELAY_W-1:0] forced_off;
        logic               status_due;
    } relay_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    // predictor state
    logic [RELAY_W-1:0]   relay_on = '0;
    count_t               on_time [RELAY_COUNT];
    count_t               max_on [RELAY_COUNT];
    int                   status_ticks = 0;

    relay_item_t          pending_items [$];
    relay_result_t        expected_results [$];

    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 1;
    int                   gap_left = 0;
    logic                 sender_no_gaps = 1'b0;
    int                   stall_mode = STALL_NONE;
    logic                 holdoff_req = 1'b0;
    logic                 holdoff_ack = 1'b0;
    int                   holdoff_left = 0;

    relay_bank_with_on_time_watchdog #(
        .RELAY_COUNT   (RELAY_COUNT),
        .STATUS_PERIOD (STATUS_PERIOD)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // mask, desired
        .s_tuser   (s_tuser),     // func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // relay_bits, forced_off
        .m_tuser   (m_tuser),     // status_due
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < RELAY_COUNT; i++) begin
            on_time[i] = '0;
            max_on[i]  = '0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic predict_relays(input logic func, input logic [RELAY_W-1:0] mask_in,
                                  input logic [RELAY_W-1:0] desired);
        relay_result_t      res;
        logic [RELAY_W-1:0] mask;
        res  = '0;
        mask = mask_in & LIVE_MASK;
        if (func == FUNC_CMD) begin
            for (int i = 0; i < RELAY_COUNT; i++) begin
                if (mask[i]) begin
                    if (desired[i]) begin
                        if (!relay_on[i]) on_time[i] = '0;
                        relay_on[i] = 1'b1;
                    end else begin
                        relay_on[i] = 1'b0;
                    end
                end
            end
            res.status_due = 1'b1;
        end else begin
            for (int i = 0; i < RELAY_COUNT; i++) begin
                if (max_on[i] != '0 && relay_on[i]) begin
                    if (on_time[i] != COUNT_MAX) on_time[i] = on_time[i] + 1'b1;
                    if (on_time[i] >= max_on[i]) begin
                        relay_on[i]       = 1'b0;
                        res.forced_off[i] = 1'b1;
                    end
                end
            end
            if (res.forced_off != '0) res.status_due = 1'b1;
            status_ticks++;
            if (status_ticks >= STATUS_PERIOD) begin
                status_ticks   = 0;
                res.status_due = 1'b1;
            end
        end
        relay_on       = relay_on & LIVE_MASK;
        res.relay_bits = relay_on;
        expected_results.push_back(res);
    endtask

    // driver
    always @(posedge aclk) begin
        relay_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_relays(s_tuser, s_tdata[RELAY_W-1:0], s_tdata[2*RELAY_W-1:RELAY_W]);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 && !sender_no_gaps) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item.func;
                    s_tdata  <= {{(TDATA_W - 2*RELAY_W){1'b0}}, item.desired, item.mask};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_req != holdoff_ack) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_ack  <= holdoff_req;
        end
    end

    // monitor
    always @(posedge aclk) begin
        relay_result_t want;
        logic          stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[RELAY_W-1:0] != want.relay_bits)
                        report_mismatch("relay_bits", int'(m_tdata[RELAY_W-1:0]),
                                        int'(want.relay_bits));
                    if (m_tdata[2*RELAY_W-1:RELAY_W] != want.forced_off)
                        report_mismatch("forced_off", int'(m_tdata[2*RELAY_W-1:RELAY_W]),
                                        int'(want.forced_off));
                    if (m_tuser != want.status_due)
                        report_mismatch("status_due", int'(m_tuser), int'(want.status_due));
                end
            end
            case (stall_mode)
                STALL_RANDOM:   stall = ($urandom_range(0, 99) < 35);
                STALL_PERIODIC: stall = ((cycle_count % 9) < 4);
                default:        stall = 1'b0;
            endcase
            m_tready <= (holdoff_left == 0) && !stall;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("relay_bank_with_on_time_watchdog_test failed");
            $finish;
        end
    end

    task automatic write_limit(input int idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_wdata <= COUNT_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        if (idx < RELAY_COUNT) max_on[idx] = COUNT_W'(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_item(input logic func, input int mask, input int desired);
        relay_item_t item;
        item.func    = func;
        item.mask    = RELAY_W'(mask);
        item.desired = RELAY_W'(desired);
        pending_items.push_back(item);
    endtask

    task automatic push_random(input int cmd_pct);
        int mask;
        if ($urandom_range(0, 99) >= cmd_pct) begin
            push_item(FUNC_TICK, $urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 2))
                0:       mask = 63;
                1:       mask = 1 << $urandom_range(0, RELAY_COUNT - 1);
                default: mask = $urandom_range(0, 63);
            endcase
            push_item(FUNC_CMD, mask, $urandom_range(0, 63));
        end
    endtask

    task automatic pick_limits(input int profile);
        int value;
        for (int i = 0; i < RELAY_COUNT; i++) begin
            case (profile)
                0: value = $urandom_range(1, 6);
                1: begin
                    case ($urandom_range(0, 3))
                        0:       value = 0;
                        1:       value = 1;
                        2:       value = $urandom_range(1, 20);
                        default: value = 65535;
                    endcase
                end
                2: value = $urandom_range(1, 60);
                default: value = $urandom_range(0, 65535);
            endcase
            write_limit(i, value);
        end
    endtask

    initial begin
        int profile;
        int cmd_pct;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        stall_mode <= STALL_RANDOM;

        // limits at reset: nothing counts
        push_item(FUNC_CMD, 0, 63);
        push_item(FUNC_CMD, 63, 63);
        push_item(FUNC_TICK, 63, 63);
        push_item(FUNC_TICK, 0, 0);
        push_item(FUNC_CMD, 63, 0);
        push_item(FUNC_CMD, 42, 63);
        drain();

        write_limit(0, 1);
        write_limit(1, 2);
        write_limit(2, 65535);
        write_limit(3, 40);
        write_limit(4, 0);
        write_limit(5, 3);
        write_limit(NUM_REGS, 7);
        write_limit(NUM_REGS + 1, 65535);
        push_item(FUNC_CMD, 63, 63);
        repeat (4) push_item(FUNC_TICK, 0, 0);
        push_item(FUNC_CMD, 63, 63);
        repeat (2) push_item(FUNC_TICK, 63, 0);
        drain();

        // lowered limit below the held count, zero limit then resumed
        write_limit(3, 2);
        write_limit(4, 7);
        write_limit(2, 0);
        push_item(FUNC_TICK, 0, 0);
        push_item(FUNC_TICK, 0, 0);
        push_item(FUNC_CMD, 63, 21);
        push_item(FUNC_TICK, 0, 0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            profile = phase % 4;
            cmd_pct = (profile == 2 || profile == 3) ? 15 : 35;
            pick_limits(profile);
            sender_no_gaps <= (phase == 2) || (phase == 4);
            case (phase % 3)
                0:       stall_mode <= STALL_RANDOM;
                1:       stall_mode <= STALL_PERIODIC;
                default: stall_mode <= STALL_NONE;
            endcase
            if (phase == 2) begin
                @(posedge aclk);
                holdoff_req <= ~holdoff_req;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_random(cmd_pct);
                if (phase == 3 && n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        sender_no_gaps <= 1'b0;
        write_limit(0, 0);
        write_limit(1, 65535);
        write_limit(2, 1);
        write_limit(3, 0);
        write_limit(4, 65535);
        write_limit(5, 1);
        for (int n = 0; n < 40; n++) push_random(40);
        drain();
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("relay_bank_with_on_time_watchdog_test passed");
        end else begin
            $display("relay_bank_with_on_time_watchdog_test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rbwd_pkg.sv
src/rbwd_relay_lane.sv
src/relay_bank_with_on_time_watchdog.sv
dv/relay_bank_with_on_time_watchdog_test.sv
